// File: design/accel_to_pan_tilt_angles_core_defines.svh
// assertion macros for the accelerometer pan/tilt core
// used by the checker module only, no other dependencies
`ifndef ACCEL_TO_PAN_TILT_ANGLES_CORE_DEFINES_SVH
`define ACCEL_TO_PAN_TILT_ANGLES_CORE_DEFINES_SVH

// clocked check, switched off while reset is held
`define ATPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define ATPT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: design/atpt_pkg.sv
// shared widths, codes, types and the cordic angle table
// for the accelerometer pan/tilt core, no dependencies
`default_nettype none

package atpt_pkg;

    localparam int unsigned IN_W        = 12;
    localparam int unsigned SENS_W      = 10;
    localparam int unsigned FRAC_SH     = 15;
    localparam int unsigned DIVD_W      = IN_W + FRAC_SH;
    localparam int unsigned DIV_STEPS   = DIVD_W;
    localparam int unsigned A_W         = 15;
    localparam int unsigned Q_SAT       = 32767;
    localparam int unsigned SQ_W        = 2 * A_W;
    localparam int unsigned M2_W        = SQ_W + 1;
    localparam logic [M2_W-1:0] ONE_SQ  = 31'd268435456;
    localparam int unsigned ISQ_W       = 30;
    localparam int unsigned ISQ_STEPS   = 15;
    localparam int unsigned ANG_W       = 14;
    localparam int unsigned PAN_W       = 15;
    localparam logic [ANG_W-1:0] ANG_RIGHT = 14'd9000;
    localparam int unsigned CORDIC_TAB_LEN = 24;
    localparam int unsigned ANGLE_ITER_DEF = 16;
    localparam int unsigned CX_W        = 19;
    localparam int unsigned CZ_W        = 24;

    localparam int unsigned ADDR_W      = 4;
    localparam int unsigned APB_DW      = 32;
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 32;
    localparam int unsigned OUT_TUSER_W = 2;

    localparam logic [IN_W-1:0]   RST_X_ZERO = 12'd1175;
    localparam logic [SENS_W-1:0] RST_X_SENS = 10'd295;
    localparam logic [IN_W-1:0]   RST_Y_ZERO = 12'd1220;
    localparam logic [SENS_W-1:0] RST_Y_SENS = 10'd290;

    localparam logic [1:0] REG_X_ZERO = 2'd0;
    localparam logic [1:0] REG_X_SENS = 2'd1;
    localparam logic [1:0] REG_Y_ZERO = 2'd2;
    localparam logic [1:0] REG_Y_SENS = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CLAMP = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    localparam logic [1:0] PK_CORDIC = 2'd0;
    localparam logic [1:0] PK_VERT   = 2'd1;
    localparam logic [1:0] PK_NONE   = 2'd2;

    typedef struct packed {
        logic [A_W-1:0] ax_mag;
        logic [A_W-1:0] ay_mag;
        logic           pan_neg;
        logic [1:0]     pan_kind;
    } t_item;

    // atan(2^-i) in 1/256 centidegree
    function automatic logic [CZ_W-1:0] atan_entry(input int unsigned idx);
        logic [CZ_W-1:0] v;
        case (idx)
            0:  v = 24'd1152000;
            1:  v = 24'd680065;
            2:  v = 24'd359328;
            3:  v = 24'd182400;
            4:  v = 24'd91554;
            5:  v = 24'd45822;
            6:  v = 24'd22916;
            7:  v = 24'd11459;
            8:  v = 24'd5730;
            9:  v = 24'd2865;
            10: v = 24'd1432;
            11: v = 24'd716;
            12: v = 24'd358;
            13: v = 24'd179;
            14: v = 24'd90;
            15: v = 24'd45;
            16: v = 24'd22;
            17: v = 24'd11;
            18: v = 24'd6;
            19: v = 24'd3;
            20: v = 24'd1;
            21: v = 24'd1;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: design/atpt_front.sv
// front end: offset removal, pipelined division by sensitivity, classification
// depends on atpt_pkg
`default_nettype none

module atpt_front
    import atpt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [IN_W-1:0]   i_x_mv,
    input  logic [IN_W-1:0]   i_y_mv,
    input  logic [IN_W-1:0]   i_x_zero,
    input  logic [SENS_W-1:0] i_x_sens,
    input  logic [IN_W-1:0]   i_y_zero,
    input  logic [SENS_W-1:0] i_y_sens,
    output logic              o_push,
    input  logic              i_full,
    output t_item             o_item
);

    localparam int unsigned LAST = DIV_STEPS + 1;
    localparam int unsigned QW   = DIVD_W + 1;

    logic [LAST:0]       r_fv;
    logic                en;
    logic [IN_W-1:0]     r_mx [0:DIV_STEPS];
    logic [IN_W-1:0]     r_my [0:DIV_STEPS];
    logic                r_nx [0:DIV_STEPS];
    logic                r_ny [0:DIV_STEPS];
    logic [SENS_W-1:0]   r_rx [0:DIV_STEPS];
    logic [SENS_W-1:0]   r_ry [0:DIV_STEPS];
    logic [DIVD_W-1:0]   r_qx [0:DIV_STEPS];
    logic [DIVD_W-1:0]   r_qy [0:DIV_STEPS];
    logic [SENS_W-1:0]   n_rx [0:DIV_STEPS-1];
    logic [SENS_W-1:0]   n_ry [0:DIV_STEPS-1];
    logic [DIVD_W-1:0]   n_qx [0:DIV_STEPS-1];
    logic [DIVD_W-1:0]   n_qy [0:DIV_STEPS-1];
    t_item               r_item;
    t_item               n_item;
    logic [SENS_W-1:0]   sx, sy;
    logic signed [IN_W:0] dx, dy;

    assign en      = !r_fv[LAST] || !i_full;
    assign o_ready = en;
    assign o_push  = r_fv[LAST] && !i_full;
    assign o_item  = r_item;

    // zero sensitivity behaves as one
    assign sx = (i_x_sens == '0) ? SENS_W'(1) : i_x_sens;
    assign sy = (i_y_sens == '0) ? SENS_W'(1) : i_y_sens;
    assign dx = $signed({1'b0, i_x_mv}) - $signed({1'b0, i_x_zero});
    assign dy = $signed({1'b0, i_y_mv}) - $signed({1'b0, i_y_zero});

    // one quotient bit per stage, restoring
    always_comb begin
        logic [DIVD_W-1:0] dvx, dvy;
        logic [SENS_W:0]   tx, ty, fx, fy;
        for (int j = 0; j < DIV_STEPS; j++) begin
            dvx = {r_mx[j], {FRAC_SH{1'b0}}};
            dvy = {r_my[j], {FRAC_SH{1'b0}}};
            tx  = {r_rx[j], dvx[DIVD_W-1-j]};
            ty  = {r_ry[j], dvy[DIVD_W-1-j]};
            fx  = tx - {1'b0, sx};
            fy  = ty - {1'b0, sy};
            if (tx >= {1'b0, sx}) begin
                n_rx[j] = fx[SENS_W-1:0];
                n_qx[j] = {r_qx[j][DIVD_W-2:0], 1'b1};
            end else begin
                n_rx[j] = tx[SENS_W-1:0];
                n_qx[j] = {r_qx[j][DIVD_W-2:0], 1'b0};
            end
            if (ty >= {1'b0, sy}) begin
                n_ry[j] = fy[SENS_W-1:0];
                n_qy[j] = {r_qy[j][DIVD_W-2:0], 1'b1};
            end else begin
                n_ry[j] = ty[SENS_W-1:0];
                n_qy[j] = {r_qy[j][DIVD_W-2:0], 1'b0};
            end
        end
    end

    // round half up, saturate, then classify the pan case
    always_comb begin
        logic [QW-1:0]  hx, hy;
        logic [A_W-1:0] axm, aym;
        logic           xneg, yneg;
        hx  = QW'(r_qx[DIV_STEPS]) + QW'(1);
        hy  = QW'(r_qy[DIV_STEPS]) + QW'(1);
        axm = (hx[QW-1:1] > DIVD_W'(Q_SAT)) ? A_W'(Q_SAT) : hx[A_W:1];
        aym = (hy[QW-1:1] > DIVD_W'(Q_SAT)) ? A_W'(Q_SAT) : hy[A_W:1];
        xneg = r_nx[DIV_STEPS] && (axm != '0);
        yneg = r_ny[DIV_STEPS] && (aym != '0);
        n_item.ax_mag = axm;
        n_item.ay_mag = aym;
        priority if (axm == '0 && aym == '0) begin
            n_item.pan_kind = PK_NONE;
            n_item.pan_neg  = 1'b0;
        end else if (axm == '0) begin
            n_item.pan_kind = PK_VERT;
            n_item.pan_neg  = yneg;
        end else begin
            n_item.pan_kind = PK_CORDIC;
            n_item.pan_neg  = xneg ^ yneg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (en) begin
            r_fv <= {r_fv[LAST-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mx[0] <= dx[IN_W] ? IN_W'(-dx) : IN_W'(dx);
            r_my[0] <= dy[IN_W] ? IN_W'(-dy) : IN_W'(dy);
            r_nx[0] <= dx[IN_W];
            r_ny[0] <= dy[IN_W];
            r_rx[0] <= '0;
            r_ry[0] <= '0;
            r_qx[0] <= '0;
            r_qy[0] <= '0;
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_mx[j+1] <= r_mx[j];
                r_my[j+1] <= r_my[j];
                r_nx[j+1] <= r_nx[j];
                r_ny[j+1] <= r_ny[j];
                r_rx[j+1] <= n_rx[j];
                r_ry[j+1] <= n_ry[j];
                r_qx[j+1] <= n_qx[j];
                r_qy[j+1] <= n_qy[j];
            end
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// File: design/atpt_queue.sv
// small request queue between the front and back ends
// depends on atpt_pkg for the request type
`default_nettype none

module atpt_queue
    import atpt_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_item         r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: design/atpt_cordic.sv
// pipelined vectoring cordic, atan2 of two non-negative values in centidegrees
// depends on atpt_pkg for widths and the angle table
`default_nettype none

module atpt_cordic
    import atpt_pkg::*;
#(
    parameter int unsigned ITERS  = ANGLE_ITER_DEF,
    parameter int unsigned SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [A_W-1:0]    i_x,
    input  logic [A_W-1:0]    i_y,
    input  logic [SIDE_W-1:0] i_side,
    output logic [ANG_W-1:0]  o_angle,
    output logic [SIDE_W-1:0] o_side
);

    localparam int unsigned N = (ITERS > CORDIC_TAB_LEN) ? CORDIC_TAB_LEN : ITERS;

    logic signed [CX_W-1:0] r_x [0:N];
    logic signed [CX_W-1:0] r_y [0:N];
    logic signed [CZ_W-1:0] r_z [0:N];
    logic                   r_fx [0:N];
    logic                   r_fy [0:N];
    logic [SIDE_W-1:0]      r_sd [0:N];
    logic signed [CX_W-1:0] n_x [0:N-1];
    logic signed [CX_W-1:0] n_y [0:N-1];
    logic signed [CZ_W-1:0] n_z [0:N-1];
    logic [ANG_W-1:0]       r_ang, n_ang;
    logic [SIDE_W-1:0]      r_sdo;

    assign o_angle = r_ang;
    assign o_side  = r_sdo;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            if (!r_y[i][CX_W-1]) begin
                n_x[i] = r_x[i] + (r_y[i] >>> i);
                n_y[i] = r_y[i] - (r_x[i] >>> i);
                n_z[i] = r_z[i] + $signed(atan_entry(i));
            end else begin
                n_x[i] = r_x[i] - (r_y[i] >>> i);
                n_y[i] = r_y[i] + (r_x[i] >>> i);
                n_z[i] = r_z[i] - $signed(atan_entry(i));
            end
        end
    end

    // clamp at zero, round to centidegrees, clamp at right angle
    always_comb begin
        logic [CZ_W-1:0] zc, zr;
        zc = r_z[N][CZ_W-1] ? '0 : r_z[N];
        zr = (zc + CZ_W'(128)) >> 8;
        priority if (r_fy[N]) begin
            n_ang = '0;
        end else if (r_fx[N]) begin
            n_ang = ANG_RIGHT;
        end else if (zr > CZ_W'(ANG_RIGHT)) begin
            n_ang = ANG_RIGHT;
        end else begin
            n_ang = zr[ANG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= CX_W'(i_x);
            r_y[0]  <= CX_W'(i_y);
            r_z[0]  <= '0;
            r_fx[0] <= (i_x == '0);
            r_fy[0] <= (i_y == '0);
            r_sd[0] <= i_side;
            for (int i = 0; i < N; i++) begin
                r_x[i+1]  <= n_x[i];
                r_y[i+1]  <= n_y[i];
                r_z[i+1]  <= n_z[i];
                r_fx[i+1] <= r_fx[i];
                r_fy[i+1] <= r_fy[i];
                r_sd[i+1] <= r_sd[i];
            end
            r_ang <= n_ang;
            r_sdo <= r_sd[N];
        end
    end

endmodule

`default_nettype wire

// File: design/atpt_back.sv
// back end: magnitude squares, two square root pipelines, two cordics, result register
// depends on atpt_pkg and atpt_cordic
`default_nettype none

module atpt_back
    import atpt_pkg::*;
#(
    parameter int unsigned ITERS = ANGLE_ITER_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  t_item                   i_q_item,
    output logic                    o_q_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [PAN_W-1:0] o_pan,
    output logic [ANG_W-1:0]        o_tilt,
    output logic [1:0]              o_status
);

    localparam int unsigned CN = (ITERS > CORDIC_TAB_LEN) ? CORDIC_TAB_LEN : ITERS;
    localparam int unsigned LB = ISQ_STEPS + 5 + CN;

    logic [LB-1:0]     r_bv;
    logic              en;
    t_item             r_b0, r_b1;
    logic [SQ_W-1:0]   r_sqx, r_sqy;
    logic [ISQ_W-1:0]  r_mv [0:ISQ_STEPS];
    logic [ISQ_W-1:0]  r_mr [0:ISQ_STEPS];
    logic [ISQ_W-1:0]  r_sv [0:ISQ_STEPS];
    logic [ISQ_W-1:0]  r_sr [0:ISQ_STEPS];
    t_item             r_ii [0:ISQ_STEPS];
    logic              r_io [0:ISQ_STEPS];
    logic [ISQ_W-1:0]  n_mv [0:ISQ_STEPS-1];
    logic [ISQ_W-1:0]  n_mr [0:ISQ_STEPS-1];
    logic [ISQ_W-1:0]  n_sv [0:ISQ_STEPS-1];
    logic [ISQ_W-1:0]  n_sr [0:ISQ_STEPS-1];
    logic [M2_W-1:0]   m2, diff;
    logic              over;
    logic [ANG_W-1:0]  pan_ang, tilt_ang;
    logic [2:0]        pan_sd;
    logic              tilt_sd;
    logic              r_ovalid;
    logic signed [PAN_W-1:0] r_pan, n_pan;
    logic [ANG_W-1:0]  r_tilt;
    logic [1:0]        r_status;

    assign en       = !r_ovalid || i_ready;
    assign o_q_pop  = en;
    assign o_valid  = r_ovalid;
    assign o_pan    = r_pan;
    assign o_tilt   = r_tilt;
    assign o_status = r_status;

    assign m2   = M2_W'(r_sqx) + M2_W'(r_sqy);
    assign over = (m2 > ONE_SQ);
    assign diff = ONE_SQ - m2;

    // bit-pair square root, one result bit per stage
    always_comb begin
        logic [ISQ_W-1:0] bitv, ta, tb;
        for (int j = 0; j < ISQ_STEPS; j++) begin
            bitv = ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - j));
            ta   = r_mr[j] + bitv;
            tb   = r_sr[j] + bitv;
            if (r_mv[j] >= ta) begin
                n_mv[j] = r_mv[j] - ta;
                n_mr[j] = (r_mr[j] >> 1) + bitv;
            end else begin
                n_mv[j] = r_mv[j];
                n_mr[j] = r_mr[j] >> 1;
            end
            if (r_sv[j] >= tb) begin
                n_sv[j] = r_sv[j] - tb;
                n_sr[j] = (r_sr[j] >> 1) + bitv;
            end else begin
                n_sv[j] = r_sv[j];
                n_sr[j] = r_sr[j] >> 1;
            end
        end
    end

    atpt_cordic #(
        .ITERS  (ITERS),
        .SIDE_W (3)
    ) u_pan (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (r_ii[ISQ_STEPS].ax_mag),
        .i_y     (r_ii[ISQ_STEPS].ay_mag),
        .i_side  ({r_ii[ISQ_STEPS].pan_kind, r_ii[ISQ_STEPS].pan_neg}),
        .o_angle (pan_ang),
        .o_side  (pan_sd)
    );

    atpt_cordic #(
        .ITERS  (ITERS),
        .SIDE_W (1)
    ) u_tilt (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (r_mr[ISQ_STEPS][A_W-1:0]),
        .i_y     (r_sr[ISQ_STEPS][A_W-1:0]),
        .i_side  (r_io[ISQ_STEPS]),
        .o_angle (tilt_ang),
        .o_side  (tilt_sd)
    );

    always_comb begin
        logic signed [PAN_W-1:0] mag;
        unique case (pan_sd[2:1])
            PK_NONE: mag = '0;
            PK_VERT: mag = PAN_W'(ANG_RIGHT);
            default: mag = PAN_W'(pan_ang);
        endcase
        n_pan = pan_sd[0] ? -mag : mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv     <= '0;
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_bv     <= {r_bv[LB-2:0], i_q_valid};
            r_ovalid <= r_bv[LB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b0  <= i_q_item;
            r_b1  <= r_b0;
            r_sqx <= SQ_W'(r_b0.ax_mag) * SQ_W'(r_b0.ax_mag);
            r_sqy <= SQ_W'(r_b0.ay_mag) * SQ_W'(r_b0.ay_mag);
            r_mv[0] <= m2[ISQ_W-1:0];
            r_sv[0] <= over ? '0 : diff[ISQ_W-1:0];
            r_mr[0] <= '0;
            r_sr[0] <= '0;
            r_ii[0] <= r_b1;
            r_io[0] <= over;
            for (int j = 0; j < ISQ_STEPS; j++) begin
                r_mv[j+1] <= n_mv[j];
                r_mr[j+1] <= n_mr[j];
                r_sv[j+1] <= n_sv[j];
                r_sr[j+1] <= n_sr[j];
                r_ii[j+1] <= r_ii[j];
                r_io[j+1] <= r_io[j];
            end
            r_pan  <= n_pan;
            r_tilt <= tilt_sd ? '0 : tilt_ang;
            priority if (tilt_sd) begin
                r_status <= ST_CLAMP;
            end else if (pan_sd[2:1] == PK_NONE) begin
                r_status <= ST_ZERO;
            end else begin
                r_status <= ST_OK;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/accel_to_pan_tilt_angles_core.sv
// accelerometer pan/tilt core, top level with the register file
// depends on atpt_pkg, atpt_front, atpt_queue, atpt_back
//
// usage
//  - s_axis carries one request per sample pair of x and y accelerometer voltages
//    in millivolts; m_axis returns one result per request, in order, holding pan and
//    tilt in centidegrees with the status code on tuser
//  - the apb port holds zero-g voltage and sensitivity per axis; write it only
//    while no request is in flight; pready is always high and reads return the value
//  - throughput is one request per clock while m_axis does not stall: every stage is a
//    register stage of a fully pipelined datapath (27-stage divider, 15-stage square
//    roots, ANGLE_ITERATIONS-stage cordics, capped at the angle table length)
//  - a stall on m_axis freezes the back end and fills the four-entry queue; the
//    front end keeps taking requests until the queue is full and its last
//    stage holds a request, then drops s_axis_tready
//  - synchronous active-low reset empties both pipelines and the queue and loads
//    the register defaults; datapath registers are not reset
`default_nettype none

module accel_to_pan_tilt_angles_core
    import atpt_pkg::*;
#(
    parameter int unsigned ANGLE_ITERATIONS = ANGLE_ITER_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request channel
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // x_voltage_mv, y_voltage_mv
    // result channel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pan_centideg, tilt_centideg, zero pad
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // status
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    logic [IN_W-1:0]   r_x_zero, r_y_zero;
    logic [SENS_W-1:0] r_x_sens, r_y_sens;
    logic              wr_en;
    logic              push, full, q_valid, q_pop;
    t_item             f_item, q_item;
    logic signed [PAN_W-1:0] pan;
    logic [ANG_W-1:0]  tilt;
    logic [1:0]        status;

    // register file
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_zero <= RST_X_ZERO;
            r_x_sens <= RST_X_SENS;
            r_y_zero <= RST_Y_ZERO;
            r_y_sens <= RST_Y_SENS;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_X_ZERO: r_x_zero <= pwdata[IN_W-1:0];
                REG_X_SENS: r_x_sens <= pwdata[SENS_W-1:0];
                REG_Y_ZERO: r_y_zero <= pwdata[IN_W-1:0];
                REG_Y_SENS: r_y_sens <= pwdata[SENS_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_X_ZERO: prdata = APB_DW'(r_x_zero);
            REG_X_SENS: prdata = APB_DW'(r_x_sens);
            REG_Y_ZERO: prdata = APB_DW'(r_y_zero);
            REG_Y_SENS: prdata = APB_DW'(r_y_sens);
        endcase
    end

    // front end: scaling to q1.14 magnitudes and pan classification
    atpt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_x_mv   (s_axis_tdata[IN_W-1:0]),
        .i_y_mv   (s_axis_tdata[2*IN_W-1:IN_W]),
        .i_x_zero (r_x_zero),
        .i_x_sens (r_x_sens),
        .i_y_zero (r_y_zero),
        .i_y_sens (r_y_sens),
        .o_push   (push),
        .i_full   (full),
        .o_item   (f_item)
    );

    // decoupling queue
    atpt_queue #(
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // back end: magnitude, square roots, angles and result register
    atpt_back #(
        .ITERS (ANGLE_ITERATIONS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_pan     (pan),
        .o_tilt    (tilt),
        .o_status  (status)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - PAN_W - ANG_W){1'b0}}, tilt, pan};
    assign m_axis_tuser = status;

endmodule

`default_nettype wire

// File: design/atpt_checker.sv
// port-level checks for the accelerometer pan/tilt core, bound to the top level
// depends on atpt_pkg and the defines header
`default_nettype none
`include "accel_to_pan_tilt_angles_core_defines.svh"

module atpt_checker
    import atpt_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    // a stalled result stays offered and unchanged
    `ATPT_ASSERT(a_hold_valid, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped under stall")
    `ATPT_ASSERT(a_hold_data, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed under stall")

    // both axes zero gives level pan and upright tilt
    `ATPT_ASSERT(a_zero_case, m_axis_tvalid && m_axis_tuser == ST_ZERO |-> m_axis_tdata[PAN_W-1:0] == '0 && m_axis_tdata[PAN_W+ANG_W-1:PAN_W] == ANG_RIGHT, "bad zero-axis result")

    // clamped magnitude gives zero tilt
    `ATPT_ASSERT(a_clamp_case, m_axis_tvalid && m_axis_tuser == ST_CLAMP |-> m_axis_tdata[PAN_W+ANG_W-1:PAN_W] == '0, "bad clamped tilt")

    // reset leaves nothing on the result channel
    `ATPT_ASSERT_RST(a_reset_empty, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind accel_to_pan_tilt_angles_core atpt_checker u_atpt_checker (.*);

`default_nettype wire
